FILE: rtl/linked_list_queue_manager_top_macros.svh
// Assertion macros shared by the linked list queue manager RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef LINKED_LIST_QUEUE_MANAGER_TOP_MACROS_SVH
`define LINKED_LIST_QUEUE_MANAGER_TOP_MACROS_SVH

// same-cycle implication
`define LLQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LLQ_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/llq_pkg.sv
// Shared types, constants and helpers for the linked list queue manager.
// No dependencies; imported by every module of the block.
`default_nettype none

package llq_pkg;

  localparam int POOL_NODES = 64;
  localparam int NODE_W     = $clog2(POOL_NODES);
  localparam int CNT_W      = $clog2(POOL_NODES + 1);
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QFILL_W    = $clog2(QDEPTH + 1);

  typedef logic [NODE_W-1:0] node_t;

  typedef struct packed {
    logic  valid;
    node_t node;
  } ptr_t;

  typedef enum logic [2:0] {
    CMD_CLEAR        = 3'd0,
    CMD_PUSH_FRONT   = 3'd1,
    CMD_PUSH_BACK    = 3'd2,
    CMD_POP_FRONT    = 3'd3,
    CMD_INSERT_AFTER = 3'd4,
    CMD_REMOVE_AFTER = 3'd5,
    CMD_READ_SUCC    = 3'd6,
    CMD_RESERVED     = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    E_IDLE,
    E_READ,
    E_READ2,
    E_WRITE2
  } eng_state_t;

  // classified request handed from front to back
  typedef struct packed {
    cmd_t  cmd;
    node_t node;
    node_t anchor;
    logic  reject;
  } req_t;

  function automatic ptr_t make_ptr(node_t n);
    ptr_t p;
    p.valid = 1'b1;
    p.node  = n;
    return p;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/llq_front.sv
// Front end: accepts requests, classifies them, and buffers them in a short queue.
// Depends on llq_pkg.
`default_nettype none

module llq_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [2:0]        command,
  input  wire llq_pkg::node_t    node,
  input  wire llq_pkg::node_t    anchor,
  input  wire logic              anchor_present,
  output llq_pkg::req_t          req,
  output logic                   req_valid,
  input  wire logic              req_take
);
  import llq_pkg::*;

  req_t               q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QFILL_W-1:0] fill;
  req_t               cls;
  logic               push;
  logic               pop;
  logic               is_anchor_cmd;

  always_comb begin
    is_anchor_cmd = (command == CMD_INSERT_AFTER) || (command == CMD_REMOVE_AFTER);
    cls.cmd    = cmd_t'(command);
    cls.node   = node;
    cls.anchor = anchor;
    // unused command code, or a null anchor where one is needed
    cls.reject = (command == CMD_RESERVED) || (is_anchor_cmd && !anchor_present);
  end

  assign in_stall  = (fill == QFILL_W'(QDEPTH));
  assign req_valid = (fill != '0);
  assign req       = q[rd_ptr];
  assign push      = in_valid && !in_stall;
  assign pop       = req_take && req_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + QFILL_W'(1);
        2'b01:   fill <= fill - QFILL_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/llq_back.sv
// Back end: sequencer over the successor memory, list registers and result register.
// Depends on llq_pkg and linked_list_queue_manager_top_macros.svh.
`default_nettype none
`include "linked_list_queue_manager_top_macros.svh"

module llq_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire llq_pkg::req_t     req,
  input  wire logic              req_valid,
  output logic                   req_take,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             status,
  output llq_pkg::node_t         result_node,
  output logic                   result_present,
  output llq_pkg::node_t         head_node,
  output logic                   is_empty,
  output logic [llq_pkg::CNT_W-1:0] entry_count
);
  import llq_pkg::*;

  ptr_t             mem [POOL_NODES];
  ptr_t             rd_data;
  ptr_t             hold;
  eng_state_t       state, state_next;
  ptr_t             head, head_next;
  ptr_t             tail, tail_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] cnt_up, cnt_dn;
  logic             out_free;
  logic             finish;
  logic             rd_en;
  node_t            rd_addr;
  logic             we;
  node_t            wa;
  ptr_t             wd;
  logic             hold_en;
  status_t          res_status;
  ptr_t             res_ptr;
  logic             an_succ_valid;

  assign out_free = !out_valid || !out_stall;
  assign cnt_up   = (count < CNT_W'(POOL_NODES)) ? count + CNT_W'(1) : count;
  assign cnt_dn   = (count != '0) ? count - CNT_W'(1) : count;
  assign req_take = finish;
  // successor of the anchor after a remove: null when the removed node pointed to itself
  assign an_succ_valid = (hold.node == req.anchor) ? 1'b0 : rd_data.valid;

  always_comb begin
    state_next = state;
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    finish     = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = req.node;
    we         = 1'b0;
    wa         = req.node;
    wd         = '0;
    hold_en    = 1'b0;
    res_status = ST_DONE;
    res_ptr    = '0;
    case (state)
      E_IDLE: begin
        if (req_valid) begin
          if (req.reject) begin
            finish     = out_free;
            res_status = ST_IGNORED;
          end else begin
            case (req.cmd)
              CMD_CLEAR: begin
                finish     = out_free;
                head_next  = '0;
                tail_next  = '0;
                count_next = '0;
              end
              CMD_PUSH_FRONT: begin
                finish = out_free;
                we     = out_free;
                wd     = (count == '0) ? '0 : head;
                if (count == '0) begin
                  tail_next = make_ptr(req.node);
                end
                head_next  = make_ptr(req.node);
                count_next = cnt_up;
              end
              CMD_PUSH_BACK: begin
                we         = 1'b1;
                state_next = E_WRITE2;
              end
              CMD_POP_FRONT: begin
                if (count == '0) begin
                  finish     = out_free;
                  res_status = ST_EMPTY;
                end else if (head.valid) begin
                  rd_en      = 1'b1;
                  rd_addr    = head.node;
                  state_next = E_READ;
                end else begin
                  finish     = out_free;
                  count_next = cnt_dn;
                end
              end
              CMD_INSERT_AFTER, CMD_REMOVE_AFTER: begin
                rd_en      = 1'b1;
                rd_addr    = req.anchor;
                state_next = E_READ;
              end
              CMD_READ_SUCC: begin
                rd_en      = 1'b1;
                state_next = E_READ;
              end
              default: begin
                finish     = out_free;
                res_status = ST_IGNORED;
              end
            endcase
          end
        end
      end
      E_READ: begin
        case (req.cmd)
          CMD_POP_FRONT: begin
            finish     = out_free;
            we         = out_free;
            wa         = head.node;
            head_next  = rd_data;
            count_next = cnt_dn;
            res_ptr    = head;
          end
          CMD_INSERT_AFTER: begin
            we         = 1'b1;
            wa         = req.anchor;
            wd         = make_ptr(req.node);
            state_next = E_WRITE2;
          end
          CMD_REMOVE_AFTER: begin
            if (!rd_data.valid) begin
              finish     = out_free;
              res_status = ST_IGNORED;
            end else begin
              hold_en    = 1'b1;
              rd_en      = 1'b1;
              rd_addr    = rd_data.node;
              state_next = E_READ2;
            end
          end
          CMD_READ_SUCC: begin
            finish  = out_free;
            res_ptr = rd_data;
          end
          default: begin
            finish     = out_free;
            res_status = ST_IGNORED;
          end
        endcase
      end
      E_READ2: begin
        we         = 1'b1;
        wa         = req.anchor;
        wd         = rd_data;
        state_next = E_WRITE2;
      end
      E_WRITE2: begin
        finish = out_free;
        case (req.cmd)
          CMD_PUSH_BACK: begin
            we = out_free && (count != '0) && tail.valid;
            wa = tail.node;
            wd = make_ptr(req.node);
            if ((count == '0) || (!tail.valid && !head.valid)) begin
              head_next = make_ptr(req.node);
            end
            tail_next  = make_ptr(req.node);
            count_next = cnt_up;
          end
          CMD_INSERT_AFTER: begin
            we = out_free;
            wd = rd_data;
            if (tail.valid && (tail.node == req.anchor)) begin
              tail_next = make_ptr(req.node);
            end
            count_next = cnt_up;
          end
          CMD_REMOVE_AFTER: begin
            we = out_free;
            wa = hold.node;
            if (!an_succ_valid) begin
              tail_next = make_ptr(req.anchor);
            end
            count_next = cnt_dn;
          end
          default: begin
            res_status = ST_IGNORED;
          end
        endcase
      end
      default: begin
        state_next = E_IDLE;
      end
    endcase
    if (finish) begin
      state_next = E_IDLE;
    end
  end

  // successor memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (hold_en) begin
      hold <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      if (finish) begin
        head  <= head_next;
        tail  <= tail_next;
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      status         <= res_status;
      result_node    <= res_ptr.valid ? res_ptr.node : '0;
      result_present <= res_ptr.valid;
      head_node      <= head_next.valid ? head_next.node : '0;
      is_empty       <= (count_next == '0);
      entry_count    <= count_next;
    end
  end

  `LLQ_ASSERT_IMP(a_busy_has_req, clk, rst, state != E_IDLE, req_valid, "engine busy without request")
  `LLQ_ASSERT_IMP(a_take_when_free, clk, rst, req_take, out_free, "finish with result register full")
  `LLQ_ASSERT_NXT(a_take_loads_out, clk, rst, req_take, out_valid, "finished request gave no result")
  `LLQ_ASSERT_IMP(a_count_max, clk, rst, 1'b1, count <= CNT_W'(POOL_NODES), "count above pool size")
  `LLQ_ASSERT_IMP(a_read2_remove, clk, rst, state == E_READ2, req.cmd == CMD_REMOVE_AFTER, "second read outside remove")

endmodule

`default_nettype wire

FILE: rtl/linked_list_queue_manager_top.sv
// Top level of the linked list queue manager: front end, request queue, back end.
// Depends on llq_pkg, llq_front and llq_back.
//
//  channel  direction  handshake            payload
//  in       to block   in_valid / in_stall  command, node, anchor, anchor_present
//  out      from block out_valid / out_stall status, result_node, result_present,
//                                           head_node, is_empty, entry_count
//
// A request enters the two-entry request queue; the back end then finishes in its
// idle step (clear, push front, errors, pop on empty or null head), after a write
// step (push back), after a read (pop, read successor, remove with nothing after
// the anchor), after a read and a write (insert after) or after two reads and a
// write (remove after): the successor memory has a registered read, one access a cycle.
// Synchronous reset empties the list and the queue; the successor memory is not cleared.
// out_stall holds the result register; the back end waits at its final step and
// in_stall rises once the request queue is full.
`default_nettype none

module linked_list_queue_manager_top (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [2:0]        command,
  input  wire llq_pkg::node_t    node,
  input  wire llq_pkg::node_t    anchor,
  input  wire logic              anchor_present,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             status,
  output llq_pkg::node_t         result_node,
  output logic                   result_present,
  output llq_pkg::node_t         head_node,
  output logic                   is_empty,
  output logic [llq_pkg::CNT_W-1:0] entry_count
);
  import llq_pkg::*;

  req_t req;
  logic req_valid;
  logic req_take;

  llq_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .node           (node),
    .anchor         (anchor),
    .anchor_present (anchor_present),
    .req            (req),
    .req_valid      (req_valid),
    .req_take       (req_take)
  );

  llq_back u_back (
    .clk            (clk),
    .rst            (rst),
    .req            (req),
    .req_valid      (req_valid),
    .req_take       (req_take),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .result_node    (result_node),
    .result_present (result_present),
    .head_node      (head_node),
    .is_empty       (is_empty),
    .entry_count    (entry_count)
  );

endmodule

`default_nettype wire

FILE: tb/linked_list_queue_manager_checker.sv
// Scoreboard for the linked list queue manager: watches the request and response
// channels, predicts every response from its own list state and compares fields.
// Depends on llq_pkg for the node, pointer, command and status types.
`default_nettype none

module linked_list_queue_manager_checker (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire logic                      in_stall,
  input  wire logic [2:0]                command,
  input  wire llq_pkg::node_t            node,
  input  wire llq_pkg::node_t            anchor,
  input  wire logic                      anchor_present,
  input  wire logic                      out_valid,
  input  wire logic                      out_stall,
  input  wire logic [1:0]                status,
  input  wire llq_pkg::node_t            result_node,
  input  wire logic                      result_present,
  input  wire llq_pkg::node_t            head_node,
  input  wire logic                      is_empty,
  input  wire logic [llq_pkg::CNT_W-1:0] entry_count,
  output int                             mismatches,
  output int                             outstanding,
  output int                             checked,
  output int                             peak_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import llq_pkg::*;

  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    status_t          status;
    node_t            result_node;
    logic             result_present;
    node_t            head_node;
    logic             is_empty;
    logic [CNT_W-1:0] entry_count;
  } response_t;

  ptr_t             next_of [POOL_NODES];
  ptr_t             head_ptr;
  ptr_t             tail_ptr;
  logic [CNT_W-1:0] linked_total;
  response_t        awaited [$];
  int               miss_total;
  int               result_total;
  int               peak_total;

  function automatic ptr_t link_to(node_t n);
    ptr_t p;
    p.valid = 1'b1;
    p.node  = n;
    return p;
  endfunction

  function automatic void count_up();
    if (linked_total < POOL_NODES) linked_total++;
  endfunction

  function automatic void count_down();
    if (linked_total > 0) linked_total--;
  endfunction

  // Applies one request to the list state and returns the response it must produce.
  function automatic response_t apply_command(logic [2:0] cmd, node_t nd, node_t an,
                                              logic an_given);
    response_t resp;
    ptr_t      got;
    ptr_t      post;
    ptr_t      gone;
    node_t     slot;
    resp = '0;
    resp.status = ST_DONE;
    got = '0;
    case (cmd)
      CMD_CLEAR: begin
        head_ptr = '0;
        tail_ptr = '0;
        linked_total = '0;
      end
      CMD_PUSH_FRONT: begin
        if (linked_total == 0) begin
          next_of[nd] = '0;
          tail_ptr = link_to(nd);
        end else begin
          next_of[nd] = head_ptr;
        end
        head_ptr = link_to(nd);
        count_up();
      end
      CMD_PUSH_BACK: begin
        next_of[nd] = '0;
        if (linked_total == 0) begin
          head_ptr = link_to(nd);
        end else if (tail_ptr.valid) begin
          next_of[tail_ptr.node] = link_to(nd);
        end else if (!head_ptr.valid) begin
          head_ptr = link_to(nd);
        end
        tail_ptr = link_to(nd);
        count_up();
      end
      CMD_POP_FRONT: begin
        if (linked_total == 0) begin
          resp.status = ST_EMPTY;
        end else begin
          count_down();
          got = head_ptr;
          if (head_ptr.valid) begin
            slot = head_ptr.node;
            head_ptr = next_of[slot];
            next_of[slot] = '0;
          end
        end
      end
      CMD_INSERT_AFTER: begin
        if (!an_given) begin
          resp.status = ST_IGNORED;
        end else begin
          post = next_of[an];
          next_of[an] = link_to(nd);
          next_of[nd] = post;
          if (tail_ptr.valid && tail_ptr.node == an) tail_ptr = link_to(nd);
          count_up();
        end
      end
      CMD_REMOVE_AFTER: begin
        if (!an_given) begin
          resp.status = ST_IGNORED;
        end else begin
          gone = next_of[an];
          if (!gone.valid) begin
            resp.status = ST_IGNORED;
          end else begin
            next_of[an] = next_of[gone.node];
            next_of[gone.node] = '0;
            if (!next_of[an].valid) tail_ptr = link_to(an);
            count_down();
          end
        end
      end
      CMD_READ_SUCC: got = next_of[nd];
      default: resp.status = ST_IGNORED;
    endcase
    resp.result_node    = got.valid ? got.node : '0;
    resp.result_present = got.valid;
    resp.head_node      = head_ptr.valid ? head_ptr.node : '0;
    resp.is_empty       = (linked_total == 0);
    resp.entry_count    = linked_total;
    return resp;
  endfunction

  task automatic note_mismatch(string field, logic [7:0] want, logic [7:0] got);
    miss_total++;
    // keep the log short when the block is badly off
    if (miss_total <= MAX_REPORTS)
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    response_t want;
    if (rst) begin
      foreach (next_of[i]) next_of[i] = '0;
      head_ptr = '0;
      tail_ptr = '0;
      linked_total = '0;
      awaited.delete();
      miss_total = 0;
      result_total = 0;
      peak_total = 0;
    end else begin
      // check responses first: a request taken at this edge cannot answer at it
      if (out_valid && !out_stall) begin
        if (awaited.size() == 0) begin
          miss_total++;
          if (miss_total <= MAX_REPORTS)
            $display("%0t: response with no request outstanding, expected none, got count %0d",
                     $time, entry_count);
        end else begin
          want = awaited.pop_front();
          result_total++;
          if (status !== want.status) note_mismatch("status", 8'(want.status), 8'(status));
          if (result_node !== want.result_node)
            note_mismatch("result_node", 8'(want.result_node), 8'(result_node));
          if (result_present !== want.result_present)
            note_mismatch("result_present", 8'(want.result_present), 8'(result_present));
          if (head_node !== want.head_node)
            note_mismatch("head_node", 8'(want.head_node), 8'(head_node));
          if (is_empty !== want.is_empty)
            note_mismatch("is_empty", 8'(want.is_empty), 8'(is_empty));
          if (entry_count !== want.entry_count)
            note_mismatch("entry_count", 8'(want.entry_count), 8'(entry_count));
        end
      end
      if (in_valid && !in_stall) begin
        awaited.push_back(apply_command(command, node, anchor, anchor_present));
        if (int'(linked_total) > peak_total) peak_total = int'(linked_total);
      end
    end
    mismatches  <= miss_total;
    outstanding <= awaited.size();
    checked     <= result_total;
    peak_count  <= peak_total;
  end

endmodule

`default_nettype wire

FILE: tb/tb_linked_list_queue_manager_top.sv
// Testbench top for the linked list queue manager: clock, reset, request stimulus
// (directed list cases, then random list traffic) and a stalling response side.
// Depends on llq_pkg, linked_list_queue_manager_top and the checker module.
`default_nettype none

module tb_linked_list_queue_manager_top;
  timeunit 1ns;
  timeprecision 1ps;

  import llq_pkg::*;

  localparam int         RANDOM_REQUESTS = 550;
  localparam int         HOLD_OFF_CYCLES = 120;
  localparam int         SETTLE_CYCLES   = 24;
  localparam int         LIMIT_CYCLES    = 200000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [2:0]       command = CMD_CLEAR;
  node_t            node = '0;
  node_t            anchor = '0;
  logic             anchor_present = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       status;
  node_t            result_node;
  logic             result_present;
  node_t            head_node;
  logic             is_empty;
  logic [CNT_W-1:0] entry_count;

  int mismatches;
  int outstanding;
  int checked;
  int peak_count;

  // stimulus-side view of the list, valid only while chain_valid is set
  bit    written [POOL_NODES];
  bit    linked [POOL_NODES];
  node_t chain [$];
  bit    chain_valid = 1'b1;
  int    goal;
  int    burst_left = 0;
  int    sent = 0;
  int    directed_sent = 0;
  bit    bulk_started = 1'b0;
  bit    hold_done = 1'b0;

  always #10 clk = ~clk;

  linked_list_queue_manager_top u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .node           (node),
    .anchor         (anchor),
    .anchor_present (anchor_present),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .result_node    (result_node),
    .result_present (result_present),
    .head_node      (head_node),
    .is_empty       (is_empty),
    .entry_count    (entry_count)
  );

  linked_list_queue_manager_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .node           (node),
    .anchor         (anchor),
    .anchor_present (anchor_present),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .result_node    (result_node),
    .result_present (result_present),
    .head_node      (head_node),
    .is_empty       (is_empty),
    .entry_count    (entry_count),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .checked        (checked),
    .peak_count     (peak_count)
  );

  function automatic node_t free_node();
    node_t n;
    do n = node_t'($urandom_range(POOL_NODES - 1)); while (linked[n]);
    return n;
  endfunction

  // only nodes whose successor entry has been written may be read back
  function automatic node_t written_node();
    node_t n;
    do n = node_t'($urandom_range(POOL_NODES - 1)); while (!written[n]);
    return n;
  endfunction

  task automatic send_request(input logic [2:0] c, input node_t nd, input node_t an,
                              input logic ap);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid       <= 1'b1;
    command        <= c;
    node           <= nd;
    anchor         <= an;
    anchor_present <= ap;
    do @(posedge clk); while (in_stall);
    if (c == CMD_PUSH_FRONT || c == CMD_PUSH_BACK || (c == CMD_INSERT_AFTER && ap))
      written[nd] = 1'b1;
    sent++;
  endtask

  initial begin : stimulus
    logic [2:0] c;
    node_t      nd;
    node_t      an;
    logic       ap;
    int         roll;
    int         pick;
    bit         grow;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_request(CMD_POP_FRONT, 6'd0, 6'd0, 1'b0);       // pop on empty list
    send_request(CMD_INSERT_AFTER, 6'd63, 6'd63, 1'b0);  // null anchor
    send_request(CMD_REMOVE_AFTER, 6'd63, 6'd63, 1'b0);
    send_request(CMD_RESERVED, 6'd42, 6'd21, 1'b0);
    send_request(CMD_PUSH_BACK, 6'd0, 6'd0, 1'b0);
    send_request(CMD_PUSH_FRONT, 6'd63, 6'd0, 1'b0);
    send_request(CMD_PUSH_BACK, 6'd21, 6'd0, 1'b0);
    send_request(CMD_INSERT_AFTER, 6'd42, 6'd0, 1'b1);
    send_request(CMD_INSERT_AFTER, 6'd1, 6'd21, 1'b1);   // after the tail: tail moves
    send_request(CMD_READ_SUCC, 6'd63, 6'd0, 1'b0);
    send_request(CMD_READ_SUCC, 6'd1, 6'd0, 1'b0);       // null successor
    send_request(CMD_REMOVE_AFTER, 6'd0, 6'd21, 1'b1);   // removes the tail
    send_request(CMD_REMOVE_AFTER, 6'd0, 6'd21, 1'b1);   // nothing after the anchor
    send_request(CMD_POP_FRONT, 6'd0, 6'd0, 1'b0);
    send_request(CMD_PUSH_BACK, 6'd62, 6'd0, 1'b0);
    send_request(CMD_CLEAR, 6'd0, 6'd0, 1'b0);
    // count without head or tail, then push back onto a null tail
    send_request(CMD_INSERT_AFTER, 6'd5, 6'd0, 1'b1);
    send_request(CMD_PUSH_BACK, 6'd7, 6'd0, 1'b0);
    send_request(CMD_POP_FRONT, 6'd0, 6'd0, 1'b0);
    send_request(CMD_POP_FRONT, 6'd0, 6'd0, 1'b0);       // null head, count nonzero
    send_request(CMD_POP_FRONT, 6'd0, 6'd0, 1'b0);
    send_request(CMD_CLEAR, 6'd63, 6'd63, 1'b1);
    directed_sent = sent;

    bulk_started = 1'b1;
    goal = $urandom_range(1, 10);
    for (int k = 0; k < RANDOM_REQUESTS; k++) begin
      c = CMD_READ_SUCC;
      nd = node_t'($urandom_range(POOL_NODES - 1));
      an = node_t'($urandom_range(POOL_NODES - 1));
      ap = 1'($urandom_range(1));
      roll = $urandom_range(99);
      if (!chain_valid && roll < 70) begin
        c = CMD_CLEAR;
      end else if (!chain_valid || roll < 8) begin
        roll = $urandom_range(99);
        if (roll < 20) begin
          c = $urandom_range(1) ? CMD_INSERT_AFTER : CMD_REMOVE_AFTER;
          ap = 1'b0;
        end else if (roll < 35) begin
          c = CMD_RESERVED;
        end else if (roll < 55) begin
          c = CMD_READ_SUCC;
          nd = written_node();
        end else if (roll < 75 && chain.size() > 0) begin
          // push a node that is already linked
          c = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
          nd = chain[$urandom_range(chain.size() - 1)];
          chain_valid = 1'b0;
        end else begin
          c = $urandom_range(1) ? CMD_INSERT_AFTER : CMD_REMOVE_AFTER;
          an = written_node();
          ap = 1'b1;
          chain_valid = 1'b0;
        end
      end else begin
        roll = $urandom_range(99);
        grow = chain.size() < goal;
        if (roll < (grow ? 50 : 20)) c = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        else if (roll < (grow ? 65 : 30)) c = CMD_INSERT_AFTER;
        else if (roll < (grow ? 75 : 60)) c = CMD_POP_FRONT;
        else if (roll < (grow ? 85 : 80)) c = CMD_REMOVE_AFTER;
        else if (roll < 97) c = CMD_READ_SUCC;
        else c = CMD_CLEAR;
        if ((c == CMD_INSERT_AFTER || c == CMD_REMOVE_AFTER) && chain.size() == 0)
          c = CMD_PUSH_BACK;
        case (c)
          CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT_AFTER: begin
            if (chain.size() == POOL_NODES) begin
              // list is full: one more push drives the count into saturation
              c = CMD_PUSH_FRONT;
              nd = chain[$urandom_range(POOL_NODES - 1)];
              chain_valid = 1'b0;
            end else begin
              nd = free_node();
              linked[nd] = 1'b1;
              if (c == CMD_PUSH_FRONT) begin
                chain.push_front(nd);
              end else if (c == CMD_PUSH_BACK) begin
                chain.push_back(nd);
              end else begin
                pick = $urandom_range(chain.size() - 1);
                an = chain[pick];
                ap = 1'b1;
                chain.insert(pick + 1, nd);
              end
            end
          end
          CMD_POP_FRONT: begin
            if (chain.size() > 0) linked[chain.pop_front()] = 1'b0;
          end
          CMD_REMOVE_AFTER: begin
            pick = $urandom_range(chain.size() - 1);
            an = chain[pick];
            ap = 1'b1;
            if (pick < chain.size() - 1) begin
              linked[chain[pick + 1]] = 1'b0;
              chain.delete(pick + 1);
            end
          end
          CMD_READ_SUCC: begin
            if (chain.size() > 0 && $urandom_range(1)) nd = chain[$urandom_range(chain.size() - 1)];
            else nd = written_node();
          end
          default: ;
        endcase
      end
      if (c == CMD_CLEAR) begin
        chain.delete();
        foreach (linked[i]) linked[i] = 1'b0;
        chain_valid = 1'b1;
        goal = ($urandom_range(7) == 0) ? POOL_NODES : $urandom_range(1, 10);
      end
      send_request(c, nd, an, ap);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("sent %0d requests (%0d directed, rest random list traffic), %0d responses checked",
             sent, directed_sent, checked);
    $display("list grew to %0d linked nodes; response side held off once for %0d cycles",
             peak_count, HOLD_OFF_CYCLES);
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // response side: stall patterns in segments, plus one long hold-off
  initial begin : receiver
    int mode;
    int span;
    int since_bulk;
    since_bulk = 0;
    forever begin
      if (bulk_started && !hold_done && since_bulk > 150) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      mode = $urandom_range(3);
      span = $urandom_range(10, 60);
      repeat (span) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(3) == 0);
          2: out_stall <= ($urandom_range(3) != 0);
          default: out_stall <= !out_stall;
        endcase
        @(posedge clk);
        if (bulk_started) since_bulk++;
      end
    end
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * 20);
    $display("timeout after %0d cycles", LIMIT_CYCLES);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
